// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Request and response types, request and status codes, and the command
// group passed from the controller to the datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_FRONT = 3'd4,
    REQ_READ_BACK  = 3'd5,
    REQ_READ_INDEX = 3'd6,
    REQ_CLEAR      = 3'd7
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    req_code_t   req_type;
    logic [31:0] data_in;
    logic [3:0]  position;
  } dq_req_t;

  typedef struct packed {
    logic [31:0] rd_data;
    status_t     status;
    logic [4:0]  occupancy;
  } dq_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the request of this transaction
    logic exec;  // carry out the captured request
  } dq_cmd_t;

endpackage

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each transaction through an execute state and a response state.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output logic            done,
  output dq_pkg::dq_cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    EXEC,
    RESP
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      IDLE: begin
        if (start) begin
          state_next = EXEC;
        end
      end
      EXEC: begin
        state_next = RESP;
      end
      RESP: begin
        // A new transaction may be taken while the response is on the bus.
        state_next = start ? EXEC : IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  assign busy     = (state == EXEC);
  assign cmd.load = start && (state != EXEC);
  assign cmd.exec = (state == EXEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == EXEC);
    end
  end

  // An accepted transaction is answered by done once the execute state has passed.
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("response strobe missing two cycles after acceptance");

  // Each transaction gives a single response strobe.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("response strobe held for more than one cycle");

endmodule

// ===== src/dq_dp.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring buffer pointer and count, request decode and result registers.
// ----------------------------------------------------------------------------
module dq_dp #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  dq_pkg::dq_cmd_t cmd,
  input  dq_pkg::dq_req_t req,
  output dq_pkg::dq_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  dq_pkg::dq_req_t   req_q;
  logic [AW-1:0]     head;
  logic [AW-1:0]     head_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  dq_pkg::status_t   status;
  dq_pkg::status_t   status_next;
  logic              rd_ok;
  logic              rd_ok_next;

  logic              wr_en;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic              full;
  logic              empty;
  logic [AW-1:0]     head_dec;

  // (base + off) modulo DEPTH, for base below DEPTH and off at most DEPTH.
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [AW:0] sum;
    sum = (AW+1)'(base) + (AW+1)'(off);
    if (sum >= (AW+1)'(DEPTH)) begin
      sum = sum - (AW+1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);

  always_comb begin
    head_next   = head;
    count_next  = count;
    status_next = dq_pkg::ST_OK;
    rd_ok_next  = 1'b0;
    wr_en       = 1'b0;
    waddr       = head;
    raddr       = head;
    case (req_q.req_type)
      dq_pkg::REQ_PUSH_FRONT: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          head_next  = head_dec;
          waddr      = head_dec;
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::REQ_PUSH_BACK: begin
        if (full) begin
          status_next = dq_pkg::ST_FULL;
        end else begin
          waddr      = ring_add(head, count);
          wr_en      = 1'b1;
          count_next = count + CW'(1);
        end
      end
      dq_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          head_next  = ring_add(head, CW'(1));
          count_next = count - CW'(1);
        end
      end
      dq_pkg::REQ_POP_BACK: begin
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      dq_pkg::REQ_READ_FRONT: begin
        raddr = head;
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          rd_ok_next = 1'b1;
        end
      end
      dq_pkg::REQ_READ_BACK: begin
        raddr = ring_add(head, count - CW'(1));
        if (empty) begin
          status_next = dq_pkg::ST_EMPTY;
        end else begin
          rd_ok_next = 1'b1;
        end
      end
      dq_pkg::REQ_READ_INDEX: begin
        raddr = ring_add(head, CW'(req_q.position));
        if (PW'(req_q.position) >= PW'(count)) begin
          status_next = dq_pkg::ST_BADPOS;
        end else begin
          rd_ok_next = 1'b1;
        end
      end
      dq_pkg::REQ_CLEAR: begin
        head_next  = '0;
        count_next = '0;
      end
      default: begin
        head_next  = head;
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.exec) begin
      status <= status_next;
    end
    if (rst) begin
      head  <= '0;
      count <= '0;
      rd_ok <= 1'b0;
    end else if (cmd.exec) begin
      head  <= head_next;
      count <= count_next;
      rd_ok <= rd_ok_next;
    end
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (waddr),
    .wdata (DATA_WIDTH'(req_q.data_in)),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rsp.rd_data   = rd_ok ? 32'(rdata) : 32'd0;
  assign rsp.status    = status;
  assign rsp.occupancy = 5'(count);

  // A dropped push leaves the occupancy untouched.
  a_full_keeps_count: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && full && (req_q.req_type == dq_pkg::REQ_PUSH_FRONT ||
                          req_q.req_type == dq_pkg::REQ_PUSH_BACK))
    |=> (count == $past(count)))
    else $error("push onto a full queue changed the count");

  // The count never passes the ring depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (count <= CW'(DEPTH)))
    else $error("entry count exceeds the queue depth");

endmodule

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of data words held in a ring buffer with a head pointer.
// ----------------------------------------------------------------------------
// A transaction is a request (push front or back, pop front or back, read
// front, back or a position counted from the front, or clear). It is
// accepted at a rising edge where start is high and busy is low; the
// request fields travel in req.
//
// Every transaction gives exactly one response on rsp, marked by done for
// a single cycle, once the request has executed. The response carries the
// word read (zero for anything but a successful read), a status code and
// the occupancy after the request. The receiver cannot stall: a response
// is taken in the cycle it appears.
//
// Each request passes through an execute state, when the store is written or
// its registered read port is addressed, and the read word is returned in
// the following cycle; a new request is accepted during that response cycle.
//
// Synchronous reset empties the queue and returns the head pointer to
// zero; stored words are not cleared and are unreachable until written.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dq_pkg::dq_req_t req,
  output logic            busy,
  output logic            done,
  output dq_pkg::dq_rsp_t rsp
);

  // Command group from the controller into the datapath.
  dq_pkg::dq_cmd_t cmd;

  // The controller only sequences; it never looks at the request payload.
  dq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // The datapath captures the request, updates pointer and count, and
  // holds the response fields steady through the response cycle.
  dq_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule
